// ===== rtl/matrix_4x4_fp32_multiply_accumulate_top_macros.svh =====
// Assertion macros for the 4x4 binary32 multiply-accumulate block.
// Used by the port checker; needs a clk and rst in scope.
`ifndef MATRIX_4X4_FP32_MULTIPLY_ACCUMULATE_TOP_MACROS_SVH
`define MATRIX_4X4_FP32_MULTIPLY_ACCUMULATE_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define MX44_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mx44 check failed");

// next-cycle implication, masked during reset
`define MX44_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mx44 check failed");

// next-cycle implication, live through reset
`define MX44_AST_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mx44 check failed");

`endif

// ===== rtl/mx44_pkg.sv =====
// Shared constants and helpers for the 4x4 binary32 multiply-accumulate block.
// No dependencies.
package mx44_pkg;

  localparam int PANEL = 4;
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;
  localparam logic [31:0] QUIET_BIT = 32'h00400000;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAC = 1'b1;

  typedef logic [31:0] f32_t;

  function automatic logic is_nan(input f32_t x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input f32_t x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input f32_t x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/mx44_fmul.sv =====
// Three-stage binary32 multiplier, round to nearest even, full denormal support.
// Depends on mx44_pkg.
module mx44_fmul import mx44_pkg::*; (
  input  logic clk,
  input  logic en,
  input  f32_t a,
  input  f32_t b,
  output f32_t y
);

  logic [7:0] ea, eb, eae, ebe;
  logic [23:0] ma, mb;
  logic sgn;
  logic spec_c;
  f32_t spec_val_c;

  logic s1_sgn, s1_spec;
  f32_t s1_spec_val;
  logic [47:0] s1_prod;
  logic signed [10:0] s1_base;

  logic s2_sgn, s2_spec;
  f32_t s2_spec_val;
  logic [47:0] s2_prod;
  logic [5:0] s2_lsh, s2_rsh;
  logic signed [10:0] s2_exp;

  logic [5:0] lz;
  logic signed [10:0] bm1, rneed;
  logic [5:0] lsh_c, rsh_c;

  logic [47:0] m;
  logic [95:0] w;
  logic [47:0] mr;
  logic stk, inc, ovf;
  logic [7:0] field;
  logic [30:0] packed_v, rounded;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    ma = {ea != 8'd0, a[22:0]};
    mb = {eb != 8'd0, b[22:0]};
    sgn = a[31] ^ b[31];
    spec_c = 1'b1;
    if (is_nan(a)) spec_val_c = a | QUIET_BIT;
    else if (is_nan(b)) spec_val_c = b | QUIET_BIT;
    else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) spec_val_c = QNAN_DEFAULT;
    else if (is_inf(a) || is_inf(b)) spec_val_c = {sgn, 8'hFF, 23'd0};
    else if (is_zero(a) || is_zero(b)) spec_val_c = {sgn, 31'd0};
    else begin
      spec_c = 1'b0;
      spec_val_c = {sgn, 31'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sgn <= sgn;
      s1_spec <= spec_c;
      s1_spec_val <= spec_val_c;
      s1_prod <= ma * mb;
      s1_base <= $signed({3'b000, eae}) + $signed({3'b000, ebe}) - 11'sd126;
    end
  end

  always_comb begin
    lz = lzc48(s1_prod);
    bm1 = s1_base - 11'sd1;
    rneed = 11'sd1 - s1_base;
    if (s1_base < 11'sd1) begin
      lsh_c = 6'd0;
      rsh_c = (rneed > 11'sd63) ? 6'd63 : rneed[5:0];
    end else begin
      rsh_c = 6'd0;
      lsh_c = ($signed({5'd0, lz}) < bm1) ? lz : bm1[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sgn <= s1_sgn;
      s2_spec <= s1_spec;
      s2_spec_val <= s1_spec_val;
      s2_prod <= s1_prod;
      s2_lsh <= lsh_c;
      s2_rsh <= rsh_c;
      s2_exp <= s1_base - $signed({5'd0, lsh_c});
    end
  end

  always_comb begin
    m = s2_prod << s2_lsh;
    w = {m, 48'd0} >> s2_rsh;
    mr = w[95:48];
    stk = (|mr[22:0]) | (|w[47:0]);
    field = mr[47] ? s2_exp[7:0] : 8'd0;
    ovf = mr[47] && (s2_exp >= 11'sd255);
    packed_v = {field, mr[46:24]};
    inc = mr[23] & (stk | mr[24]);
    rounded = packed_v + {30'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_spec) y <= s2_spec_val;
      else if (ovf) y <= {s2_sgn, 8'hFF, 23'd0};
      else y <= {s2_sgn, rounded};
    end
  end

endmodule

// ===== rtl/mx44_fadd.sv =====
// Three-stage binary32 adder, round to nearest even, full denormal support.
// Depends on mx44_pkg.
module mx44_fadd import mx44_pkg::*; (
  input  logic clk,
  input  logic en,
  input  f32_t a,
  input  f32_t b,
  output f32_t y
);

  f32_t x, z;
  logic [7:0] exe, eze, diff;
  logic [4:0] dcap;
  logic [26:0] xm, zm;
  logic [53:0] wide;
  logic spec_c;
  f32_t spec_val_c;

  logic s1_sgn, s1_sub, s1_spec;
  f32_t s1_spec_val;
  logic [26:0] s1_xm, s1_zm;
  logic [7:0] s1_exe;

  logic [27:0] sum;
  logic [4:0] lz, lsh_c;

  logic s2_sgn, s2_spec, s2_zero;
  f32_t s2_spec_val;
  logic [27:0] s2_sum;
  logic [4:0] s2_lsh;
  logic [8:0] s2_exp;

  logic [27:0] m;
  logic [7:0] field;
  logic ovf, inc;
  logic [30:0] packed_v, rounded;

  always_comb begin
    if (b[30:0] > a[30:0]) begin
      x = b;
      z = a;
    end else begin
      x = a;
      z = b;
    end
    exe = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    eze = (z[30:23] == 8'd0) ? 8'd1 : z[30:23];
    diff = exe - eze;
    dcap = (diff > 8'd31) ? 5'd31 : diff[4:0];
    xm = {x[30:23] != 8'd0, x[22:0], 3'b000};
    zm = {z[30:23] != 8'd0, z[22:0], 3'b000};
    wide = {zm, 27'd0} >> dcap;
    spec_c = 1'b1;
    if (is_nan(a)) spec_val_c = a | QUIET_BIT;
    else if (is_nan(b)) spec_val_c = b | QUIET_BIT;
    else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) spec_val_c = QNAN_DEFAULT;
    else if (is_inf(a)) spec_val_c = a;
    else if (is_inf(b)) spec_val_c = b;
    else begin
      spec_c = 1'b0;
      spec_val_c = a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sgn <= x[31];
      s1_sub <= x[31] ^ z[31];
      s1_spec <= spec_c;
      s1_spec_val <= spec_val_c;
      s1_xm <= xm;
      s1_zm <= {wide[53:28], wide[27] | (|wide[26:0])};
      s1_exe <= exe;
    end
  end

  always_comb begin
    sum = s1_sub ? ({1'b0, s1_xm} - {1'b0, s1_zm}) : ({1'b0, s1_xm} + {1'b0, s1_zm});
    lz = lzc28(sum);
    lsh_c = ({3'd0, lz} < s1_exe) ? lz : s1_exe[4:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sgn <= s1_sub ? (s1_sgn & (sum != 28'd0)) : s1_sgn;
      s2_spec <= s1_spec;
      s2_spec_val <= s1_spec_val;
      s2_zero <= sum == 28'd0;
      s2_sum <= sum;
      s2_lsh <= lsh_c;
      s2_exp <= {1'b0, s1_exe} + 9'd1 - {4'd0, lsh_c};
    end
  end

  always_comb begin
    m = s2_sum << s2_lsh;
    field = m[27] ? s2_exp[7:0] : 8'd0;
    ovf = m[27] && (s2_exp >= 9'd255);
    packed_v = {field, m[26:4]};
    inc = m[3] & ((|m[2:0]) | m[4]);
    rounded = packed_v + {30'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_spec) y <= s2_spec_val;
      else if (s2_zero) y <= {s2_sgn, 31'd0};
      else if (ovf) y <= {s2_sgn, 8'hFF, 23'd0};
      else y <= {s2_sgn, rounded};
    end
  end

endmodule

// ===== rtl/matrix_4x4_fp32_multiply_accumulate_top.sv =====
// Each accepted multiply-accumulate beat passes through three multiplier stages,
// then four chained three-stage adders per row, before its result beat leaves.
// Throughput: one beat per cycle; load beats give no result.
// The whole pipeline holds while the output register is full and not taken.
// rst clears the valid bits only; the left matrix holds garbage until loaded.
module matrix_4x4_fp32_multiply_accumulate_top import mx44_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,  // vec0, vec1, vec2, vec3, acc0, acc1, acc2, acc3
  input  logic [2:0]   s_tuser,  // opcode, column_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata   // res0, res1, res2, res3
);

  localparam int DEPTH = 15;

  logic en, acc_beat;
  f32_t lm [PANEL][PANEL];
  f32_t vec [PANEL];
  f32_t prod [PANEL][PANEL];
  f32_t cdl [PANEL][3];
  f32_t pdl [PANEL][PANEL][9];
  f32_t part [PANEL][PANEL+1];
  logic [DEPTH-1:0] vld;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc_beat = s_tvalid && s_tready;
  assign m_tvalid = vld[DEPTH-1];

  always_comb begin
    for (int k = 0; k < PANEL; k++) vec[k] = s_tdata[32*k +: 32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], acc_beat && (s_tuser[0] == OP_MAC)};
    end
  end

  always_ff @(posedge clk) begin
    if (acc_beat && (s_tuser[0] == OP_LOAD)) begin
      for (int r = 0; r < PANEL; r++) lm[s_tuser[2:1]][r] <= vec[r];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < PANEL; i++) begin
        cdl[i][0] <= s_tdata[128 + 32*i +: 32];
        cdl[i][1] <= cdl[i][0];
        cdl[i][2] <= cdl[i][1];
        for (int k = 0; k < PANEL; k++) begin
          pdl[i][k][0] <= prod[i][k];
          for (int d = 1; d < 9; d++) pdl[i][k][d] <= pdl[i][k][d-1];
        end
      end
    end
  end

  for (genvar i = 0; i < PANEL; i++) begin : g_row
    assign part[i][0] = cdl[i][2];
    for (genvar k = 0; k < PANEL; k++) begin : g_term
      mx44_fmul u_mul (
        .clk(clk), .en(en), .a(lm[k][i]), .b(vec[k]), .y(prod[i][k])
      );
      if (k == 0) begin : g_first
        mx44_fadd u_add (
          .clk(clk), .en(en), .a(part[i][0]), .b(prod[i][0]), .y(part[i][1])
        );
      end else begin : g_rest
        mx44_fadd u_add (
          .clk(clk), .en(en), .a(part[i][k]), .b(pdl[i][k][3*k-1]), .y(part[i][k+1])
        );
      end
    end
    assign m_tdata[32*i +: 32] = part[i][PANEL];
  end

endmodule

// ===== rtl/mx44_port_chk.sv =====
// Port-level checker for the 4x4 binary32 multiply-accumulate block, with its bind.
// Depends on matrix_4x4_fp32_multiply_accumulate_top_macros.svh.
`include "matrix_4x4_fp32_multiply_accumulate_top_macros.svh"

module mx44_port_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  `MX44_AST_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `MX44_AST_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
  `MX44_AST_NOW(a_ready_when_empty, !m_tvalid || m_tready, s_tready)
  `MX44_AST_RST(a_reset_empty, rst, !m_tvalid)

endmodule

bind matrix_4x4_fp32_multiply_accumulate_top mx44_port_chk u_port_chk (.*);
